// ===== sv/dch2_pkg.sv =====
// ============================================================================
// dch2_pkg
// Shared constants, types and helper functions of the dominant color
// histogram block.
// ============================================================================
package dch2_pkg;

    localparam int LEVELS     = 16;
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int BIN_W      = 3 * LVL_W;
    localparam int NBINS      = LEVELS * LEVELS * LEVELS;
    localparam int CNT_W      = 25;
    localparam int MAX_SIDE   = 4096;
    localparam int SIDE_W     = 13;
    localparam int MIN_SIDE   = 16;
    localparam int SHARE_W    = 16;
    localparam int COLOR_W    = 9;
    localparam int STEP_W     = 8;
    localparam int BLK_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W      = 8;
    localparam int THR_W      = 12;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        HOP_IDLE,
        HOP_COUNT,
        HOP_SCAN,
        HOP_CLEAR
    } hist_op_t;

    typedef struct packed {
        hist_op_t         op;
        logic [BIN_W-1:0] addr;
    } hist_cmd_t;

    typedef struct packed {
        logic [BIN_W-1:0] best_bin;
        logic [CNT_W-1:0] best_total;
        logic [BIN_W-1:0] second_bin;
        logic [CNT_W-1:0] second_total;
    } top2_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN_SCAN,
        ST_DRAIN_CLR,
        ST_SCAN,
        ST_SETTLE,
        ST_DIV0_GO,
        ST_DIV0_WAIT,
        ST_DIV1_GO,
        ST_DIV1_WAIT
    } state_t;

    // Step size round(255 / n) for the effective block count n.
    function automatic logic [STEP_W-1:0] step_lookup(input logic [BLK_W-1:0] n);
        logic [STEP_W-1:0] s;
        case (n)
            5'd0:    s = 8'd255;
            5'd1:    s = 8'd255;
            5'd2:    s = 8'd128;
            5'd3:    s = 8'd85;
            5'd4:    s = 8'd64;
            5'd5:    s = 8'd51;
            5'd6:    s = 8'd43;
            5'd7:    s = 8'd36;
            5'd8:    s = 8'd32;
            5'd9:    s = 8'd28;
            5'd10:   s = 8'd26;
            5'd11:   s = 8'd23;
            5'd12:   s = 8'd21;
            5'd13:   s = 8'd20;
            5'd14:   s = 8'd18;
            5'd15:   s = 8'd17;
            default: s = 8'd16;
        endcase
        return s;
    endfunction

    // Representative value level * step + round(step / 2), kept to 9 bits.
    function automatic logic [COLOR_W-1:0] color_of(input logic [LVL_W-1:0] q,
                                                    input logic [STEP_W-1:0] step);
        logic [THR_W-1:0]  prod;
        logic [STEP_W:0]   half;
        logic [THR_W-1:0]  sum;
        prod = THR_W'(q) * THR_W'(step);
        half = ({1'b0, step} + 9'd1) >> 1;
        sum  = prod + THR_W'(half);
        return sum[COLOR_W-1:0];
    endfunction

endpackage

// ===== sv/dominant_color_histogram_top2_top.sv =====
// ============================================================================
// dominant_color_histogram_top2_top
// Color histogram of one BGR frame; reports the two most frequent colors.
// ============================================================================
// Pixels are accepted one per cycle while busy is low; the bin count is a
// read-modify-write on the histogram memory, behind the quantizer's bin register.
// An error item's result appears in the cycle after acceptance.
// The frame's last pixel starts a drain, a scan (one memory read per bin), a
// settle state, then a run of the serial share divider for each result. The
// receiver cannot stall results.
// Reset starts a clearing pass over every bin of the histogram memory; an error
// item arriving with a partly counted frame starts the same pass.
module dominant_color_histogram_top2_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dch2_pkg::PIX_W-1:0]      blue,
    input  logic [dch2_pkg::PIX_W-1:0]      green,
    input  logic [dch2_pkg::PIX_W-1:0]      red,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dch2_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dch2_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            result_valid,
    output logic                            status,
    output logic                            rank,
    output logic [dch2_pkg::COLOR_W-1:0]    color_blue,
    output logic [dch2_pkg::COLOR_W-1:0]    color_green,
    output logic [dch2_pkg::COLOR_W-1:0]    color_red,
    output logic [dch2_pkg::CNT_W-1:0]      pixel_count,
    output logic [dch2_pkg::SHARE_W-1:0]    share,
    output logic                            last_result
);
    import dch2_pkg::*;

    state_t state_reg, state_next;

    logic [BLK_W-1:0]   blocks_reg;
    logic [SIDE_W-1:0]  width_reg;
    logic [SIDE_W-1:0]  height_reg;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic [BIN_W-1:0]   addr_reg, addr_next;
    logic               dirty_reg, dirty_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_status_reg, out_status_next;
    logic               out_rank_reg, out_rank_next;
    logic [COLOR_W-1:0] out_blue_reg, out_blue_next;
    logic [COLOR_W-1:0] out_green_reg, out_green_next;
    logic [COLOR_W-1:0] out_red_reg, out_red_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;
    logic [SHARE_W-1:0] out_share_reg, out_share_next;
    logic               out_last_reg, out_last_next;

    logic [SIDE_W-1:0]  w_eff;
    logic [SIDE_W-1:0]  h_eff;
    logic [2*SIDE_W-1:0] area;
    logic [CNT_W-1:0]   total;
    logic               size_err;
    logic [STEP_W-1:0]  step;
    logic               accept;
    logic               frame_end;
    logic [CNT_W:0]     seen_inc;

    logic               q_valid;
    logic [BIN_W-1:0]   q_bin;
    hist_cmd_t          cmd;
    logic               hist_pending;
    top2_t              top2;

    logic               div_start;
    logic [CNT_W-1:0]   div_count;
    logic               div_done;
    logic [SHARE_W-1:0] div_share;
    logic [BIN_W-1:0]   emit_bin;

    assign w_eff    = (width_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : width_reg;
    assign h_eff    = (height_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : height_reg;
    assign area     = w_eff * h_eff;
    assign total    = area[CNT_W-1:0];
    assign size_err = (w_eff < SIDE_W'(MIN_SIDE)) || (h_eff < SIDE_W'(MIN_SIDE));
    assign step     = step_lookup(blocks_reg);

    assign busy      = (state_reg != ST_RUN);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign seen_inc  = {1'b0, seen_reg} + 1'b1;
    assign frame_end = seen_inc >= {1'b0, total};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_reg <= BLK_W'(8);
            width_reg  <= SIDE_W'(64);
            height_reg <= SIDE_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BLOCKS: blocks_reg <= cfg_data[BLK_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    dch2_quant u_quant (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept && !size_err),
        .step      (step),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .bin_valid (q_valid),
        .bin       (q_bin)
    );

    always_comb
    begin
        cmd.addr = q_valid ? q_bin : addr_reg;
        if (q_valid)
        begin
            cmd.op = HOP_COUNT;
        end
        else if (state_reg == ST_SCAN)
        begin
            cmd.op = HOP_SCAN;
        end
        else if (state_reg == ST_CLEAR)
        begin
            cmd.op = HOP_CLEAR;
        end
        else
        begin
            cmd.op = HOP_IDLE;
        end
    end

    dch2_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .pending (hist_pending),
        .top2    (top2)
    );

    assign div_count = (state_reg == ST_DIV1_GO) ? top2.second_total : top2.best_total;

    dch2_share u_share (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .count (div_count),
        .total (total),
        .done  (div_done),
        .share (div_share)
    );

    assign emit_bin = (state_reg == ST_DIV1_WAIT) ? top2.second_bin : top2.best_bin;

    always_comb
    begin
        state_next      = state_reg;
        seen_next       = seen_reg;
        addr_next       = addr_reg;
        dirty_next      = dirty_reg;
        div_start       = 1'b0;
        out_valid_next  = 1'b0;
        out_status_next = out_status_reg;
        out_rank_next   = out_rank_reg;
        out_blue_next   = out_blue_reg;
        out_green_next  = out_green_reg;
        out_red_next    = out_red_reg;
        out_count_next  = out_count_reg;
        out_share_next  = out_share_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == BIN_W'(NBINS - 1))
                begin
                    dirty_next = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    if (size_err)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = 1'b1;
                        out_rank_next   = 1'b0;
                        out_blue_next   = '0;
                        out_green_next  = '0;
                        out_red_next    = '0;
                        out_count_next  = '0;
                        out_share_next  = '0;
                        out_last_next   = 1'b1;
                        seen_next       = '0;
                        if (dirty_reg)
                        begin
                            state_next = ST_DRAIN_CLR;
                        end
                    end
                    else
                    begin
                        dirty_next = 1'b1;
                        if (frame_end)
                        begin
                            seen_next  = '0;
                            state_next = ST_DRAIN_SCAN;
                        end
                        else
                        begin
                            seen_next = seen_inc[CNT_W-1:0];
                        end
                    end
                end
            end
            ST_DRAIN_SCAN, ST_DRAIN_CLR:
            begin
                // Let the last count finish its write-back before sweeping.
                if (!q_valid && !hist_pending)
                begin
                    addr_next  = '0;
                    state_next = (state_reg == ST_DRAIN_SCAN) ? ST_SCAN : ST_CLEAR;
                end
            end
            ST_SCAN:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == BIN_W'(NBINS - 1))
                begin
                    dirty_next = 1'b0;
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_DIV0_GO;
            end
            ST_DIV0_GO:
            begin
                if (top2.best_total == '0)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV0_WAIT;
                end
            end
            ST_DIV1_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV1_WAIT;
            end
            ST_DIV0_WAIT, ST_DIV1_WAIT:
            begin
                if (div_done)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = 1'b0;
                    out_blue_next   = color_of(emit_bin[BIN_W-1 -: LVL_W], step);
                    out_green_next  = color_of(emit_bin[2*LVL_W-1 -: LVL_W], step);
                    out_red_next    = color_of(emit_bin[LVL_W-1:0], step);
                    out_share_next  = div_share;
                    if (state_reg == ST_DIV0_WAIT)
                    begin
                        out_rank_next  = 1'b0;
                        out_count_next = top2.best_total;
                        out_last_next  = (top2.second_total == '0);
                        state_next     = (top2.second_total == '0) ? ST_RUN : ST_DIV1_GO;
                    end
                    else
                    begin
                        out_rank_next  = 1'b1;
                        out_count_next = top2.second_total;
                        out_last_next  = 1'b1;
                        state_next     = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            seen_reg      <= '0;
            addr_reg      <= '0;
            dirty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            addr_reg      <= addr_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_rank_reg   <= out_rank_next;
        out_blue_reg   <= out_blue_next;
        out_green_reg  <= out_green_next;
        out_red_reg    <= out_red_next;
        out_count_reg  <= out_count_next;
        out_share_reg  <= out_share_next;
        out_last_reg   <= out_last_next;
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign rank         = out_rank_reg;
    assign color_blue   = out_blue_reg;
    assign color_green  = out_green_reg;
    assign color_red    = out_red_reg;
    assign pixel_count  = out_count_reg;
    assign share        = out_share_reg;
    assign last_result  = out_last_reg;

    a_second_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && rank) |-> (last_result && !status))
        else $error("second color item is not the final ok item");

    a_error_item: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> (last_result && (pixel_count == '0)))
        else $error("error item carries a count or is not final");

    a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (!q_valid && !hist_pending))
        else $error("pixel count in flight during histogram scan");

    a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && rank) |-> (pixel_count <= top2.best_total))
        else $error("second color count exceeds the first");

endmodule

// ===== sv/dch2_quant.sv =====
// ============================================================================
// dch2_quant
// Quantizes one BGR pixel to its histogram bin and registers the bin.
// ============================================================================
module dch2_quant (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [dch2_pkg::STEP_W-1:0] step,
    input  logic [dch2_pkg::PIX_W-1:0]  blue,
    input  logic [dch2_pkg::PIX_W-1:0]  green,
    input  logic [dch2_pkg::PIX_W-1:0]  red,
    output logic                        bin_valid,
    output logic [dch2_pkg::BIN_W-1:0]  bin
);
    import dch2_pkg::*;

    logic             bin_valid_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [BIN_W-1:0] bin_next;

    // The level is the number of multiples of step that do not exceed the
    // value, which also holds it at LEVELS-1.
    function automatic logic [LVL_W-1:0] level_of(input logic [PIX_W-1:0] p,
                                                  input logic [STEP_W-1:0] s);
        logic [THR_W-1:0] thr;
        logic [LVL_W-1:0] q;
        q = '0;
        for (int k = 1; k < LEVELS; k++)
        begin
            thr = THR_W'(k) * THR_W'(s);
            if (thr <= THR_W'(p))
            begin
                q = q + 1'b1;
            end
        end
        return q;
    endfunction

    assign bin_next = {level_of(blue, step), level_of(green, step), level_of(red, step)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= 1'b0;
        end
        else
        begin
            bin_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            bin_reg <= bin_next;
        end
    end

    assign bin_valid = bin_valid_reg;
    assign bin       = bin_reg;

endmodule

// ===== sv/dch2_hist.sv =====
// ============================================================================
// dch2_hist
// Histogram memory with read-modify-write counting, a scan that reads and
// zeroes every bin while tracking the two largest, and a clearing pass.
// ============================================================================
module dch2_hist (
    input  logic                clk,
    input  logic                rst_n,
    input  dch2_pkg::hist_cmd_t cmd,
    output logic                pending,
    output dch2_pkg::top2_t     top2
);
    import dch2_pkg::*;

    logic [CNT_W-1:0] mem [NBINS];

    logic [CNT_W-1:0] rdata_reg;
    hist_op_t         s2_op_reg;
    logic [BIN_W-1:0] s2_addr_reg;
    logic             fwd_valid_reg;
    logic [BIN_W-1:0] fwd_addr_reg;
    logic [CNT_W-1:0] fwd_data_reg;
    top2_t            top2_reg;
    top2_t            top2_next;

    logic             re;
    logic             we;
    logic [BIN_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] inc;
    logic             count_wr;
    top2_t            base;

    assign re = (cmd.op == HOP_COUNT) || (cmd.op == HOP_SCAN);

    // A count written back in the previous cycle is not yet in the read data.
    assign cur = (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg)) ? fwd_data_reg
                                                                  : rdata_reg;
    assign inc      = (cur == CNT_MAX) ? cur : cur + 1'b1;
    assign count_wr = (s2_op_reg == HOP_COUNT);

    always_comb
    begin
        we    = 1'b0;
        waddr = cmd.addr;
        wdata = '0;
        if (count_wr)
        begin
            we    = 1'b1;
            waddr = s2_addr_reg;
            wdata = inc;
        end
        else if ((cmd.op == HOP_SCAN) || (cmd.op == HOP_CLEAR))
        begin
            we = 1'b1;
        end
    end

    always_comb
    begin
        base      = (s2_addr_reg == '0) ? '0 : top2_reg;
        top2_next = top2_reg;
        if (s2_op_reg == HOP_SCAN)
        begin
            top2_next = base;
            if (rdata_reg > base.best_total)
            begin
                top2_next.second_bin   = base.best_bin;
                top2_next.second_total = base.best_total;
                top2_next.best_bin     = s2_addr_reg;
                top2_next.best_total   = rdata_reg;
            end
            else if (rdata_reg > base.second_total)
            begin
                top2_next.second_bin   = s2_addr_reg;
                top2_next.second_total = rdata_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        s2_addr_reg  <= cmd.addr;
        fwd_addr_reg <= s2_addr_reg;
        fwd_data_reg <= inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_op_reg     <= HOP_IDLE;
            fwd_valid_reg <= 1'b0;
            top2_reg      <= '0;
        end
        else
        begin
            s2_op_reg     <= re ? cmd.op : HOP_IDLE;
            fwd_valid_reg <= count_wr;
            top2_reg      <= top2_next;
        end
    end

    assign pending = count_wr;
    assign top2    = top2_reg;

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        count_wr |-> !((cmd.op == HOP_SCAN) || (cmd.op == HOP_CLEAR)))
        else $error("count write-back collides with scan or clear write");

endmodule

// ===== sv/dch2_share.sv =====
// ============================================================================
// dch2_share
// Serial divider for the Q0.16 share of a bin: round(count * 65536 / total),
// saturated, one quotient bit per cycle.
// ============================================================================
module dch2_share (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [dch2_pkg::CNT_W-1:0]   count,
    input  logic [dch2_pkg::CNT_W-1:0]   total,
    output logic                         done,
    output logic [dch2_pkg::SHARE_W-1:0] share
);
    import dch2_pkg::*;

    localparam int STEPS_W = $clog2(SHARE_W + 1);

    logic                 run_reg;
    logic [STEPS_W-1:0]   steps_reg;
    logic [CNT_W:0]       rem_reg;
    logic [SHARE_W-1:0]   quo_reg;
    logic [CNT_W-1:0]     den_reg;
    logic                 done_reg;
    logic [SHARE_W-1:0]   share_reg;

    logic [CNT_W:0]       rem_sh;
    logic                 fits;
    logic [CNT_W:0]       rem_rnd;
    logic [SHARE_W:0]     quo_rnd;

    assign rem_sh = {rem_reg[CNT_W-1:0], 1'b0};
    assign fits   = rem_sh >= {1'b0, den_reg};
    // Rounding: add half the divisor to the final remainder.
    assign rem_rnd = rem_reg + {2'b0, den_reg[CNT_W-1:1]};
    assign quo_rnd = {1'b0, quo_reg} + ((rem_rnd >= {1'b0, den_reg}) ? 17'd1 : 17'd0);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, count};
            quo_reg <= '0;
            den_reg <= total;
        end
        else if (run_reg && (steps_reg != '0))
        begin
            rem_reg <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
            quo_reg <= {quo_reg[SHARE_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            steps_reg <= '0;
            done_reg  <= 1'b0;
            share_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (count >= total)
                begin
                    done_reg  <= 1'b1;
                    share_reg <= {SHARE_W{1'b1}};
                end
                else
                begin
                    run_reg   <= 1'b1;
                    steps_reg <= STEPS_W'(SHARE_W);
                end
            end
            else if (run_reg)
            begin
                if (steps_reg != '0)
                begin
                    steps_reg <= steps_reg - 1'b1;
                end
                else
                begin
                    run_reg   <= 1'b0;
                    done_reg  <= 1'b1;
                    share_reg <= quo_rnd[SHARE_W] ? {SHARE_W{1'b1}} : quo_rnd[SHARE_W-1:0];
                end
            end
        end
    end

    assign done  = done_reg;
    assign share = share_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("share divider restarted while busy");

endmodule

// ===== dv/dominant_color_histogram_top2_top_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// dominant_color_histogram_top2_top_test
// Self-checking bench for the top-two color histogram. A queue of pixel and
// register-write items feeds a falling-edge driver; a rising-edge monitor
// predicts each frame's dominant colors and checks every result strobe.
// ============================================================================
module dominant_color_histogram_top2_top_test;
    import dch2_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 5;
    // Longer than the clearing pass that follows reset or a rejected pixel.
    localparam int SETTLE_CYCLES = 4300;
    localparam int TAIL_CYCLES   = 4400;
    localparam int STALL_LIMIT   = 30000;
    localparam int PRINT_LIMIT   = 40;
    localparam int GAP_NONE      = 0;
    localparam int GAP_HEAVY     = 47;
    localparam int GAP_LIGHT     = 30;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_SIZE = 1'b1;
    localparam logic RANK_FIRST      = 1'b0;
    localparam logic RANK_SECOND     = 1'b1;

    typedef enum bit {STIM_PIXEL, STIM_CFG} stim_kind_t;

    typedef struct packed {
        stim_kind_t            kind;
        logic [6:0]            gap_pct;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [PIX_W-1:0]      b;
        logic [PIX_W-1:0]      g;
        logic [PIX_W-1:0]      r;
    } stim_t;

    typedef struct packed {
        logic               status;
        logic               rank;
        logic [COLOR_W-1:0] color_blue;
        logic [COLOR_W-1:0] color_green;
        logic [COLOR_W-1:0] color_red;
        logic [CNT_W-1:0]   pixel_count;
        logic [SHARE_W-1:0] share;
        logic               last_result;
    } color_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [PIX_W-1:0]      blue = '0;
    logic [PIX_W-1:0]      green = '0;
    logic [PIX_W-1:0]      red = '0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  busy;
    logic                  cfg_ready;
    logic                  result_valid;
    logic                  status;
    logic                  rank;
    logic [COLOR_W-1:0]    color_blue;
    logic [COLOR_W-1:0]    color_green;
    logic [COLOR_W-1:0]    color_red;
    logic [CNT_W-1:0]      pixel_count;
    logic [SHARE_W-1:0]    share;
    logic                  last_result;

    dominant_color_histogram_top2_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .blue         (blue),
        .green        (green),
        .red          (red),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status       (status),
        .rank         (rank),
        .color_blue   (color_blue),
        .color_green  (color_green),
        .color_red    (color_red),
        .pixel_count  (pixel_count),
        .share        (share),
        .last_result  (last_result)
    );

    // Stimulus and bookkeeping.
    stim_t         pending[$];
    color_result_t color_q[$];
    int            phase_gap = GAP_NONE;
    logic          item_taken = 1'b0;
    logic          cfg_taken = 1'b0;
    int            quiet_cycles = 0;
    int            stall_cycles = 0;
    int            mismatch_count = 0;
    int            pixels_sent = 0;
    int            cfg_writes = 0;
    int            frames_done = 0;
    int            rejects_seen = 0;

    // Shadow copy of the block's registers and histogram.
    logic [BLK_W-1:0]  shadow_blocks = 5'd8;
    logic [SIDE_W-1:0] shadow_width = 13'd64;
    logic [SIDE_W-1:0] shadow_height = 13'd64;
    logic [CNT_W-1:0]  bin_tally [NBINS];
    int unsigned       frame_fill = 0;

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic report_error(string msg);
        mismatch_count++;
        // Keep the log short when a systematic fault hits every result.
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic check_field(string name, longint unsigned got, longint unsigned want);
        if (got != want)
            report_error($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    function automatic int unsigned clamp_side(logic [SIDE_W-1:0] s);
        return (s > MAX_SIDE) ? MAX_SIDE : int'(s);
    endfunction

    function automatic int unsigned level_of(logic [PIX_W-1:0] p, int unsigned stp);
        int unsigned q;
        q = int'(p) / stp;
        return (q > LEVELS - 1) ? LEVELS - 1 : q;
    endfunction

    task automatic clear_histogram();
        foreach (bin_tally[i])
            bin_tally[i] = '0;
        frame_fill = 0;
    endtask

    function automatic color_result_t make_color(logic rnk, int unsigned bin, int unsigned cnt,
                                                 int unsigned total, int unsigned stp,
                                                 logic is_last);
        color_result_t res;
        int unsigned   half;
        logic [63:0]   frac;
        half = (stp + 1) / 2;
        frac = ((64'(cnt) << 16) + 64'(total / 2)) / 64'(total);
        res = '0;
        res.status      = STATUS_OK;
        res.rank        = rnk;
        res.color_blue  = COLOR_W'((bin / (LEVELS * LEVELS)) * stp + half);
        res.color_green = COLOR_W'(((bin / LEVELS) % LEVELS) * stp + half);
        res.color_red   = COLOR_W'((bin % LEVELS) * stp + half);
        res.pixel_count = CNT_W'(cnt);
        res.share       = (frac > 64'd65535) ? 16'hFFFF : frac[15:0];
        res.last_result = is_last;
        return res;
    endfunction

    // Counts one accepted pixel and queues whatever results it causes.
    task automatic predict_pixel(logic [PIX_W-1:0] pb, logic [PIX_W-1:0] pg,
                                 logic [PIX_W-1:0] pr);
        int unsigned   w, h, n, stp, bin, total;
        int unsigned   best_b, best_t, sec_b, sec_t, c;
        color_result_t res;
        w = clamp_side(shadow_width);
        h = clamp_side(shadow_height);
        if (w < MIN_SIDE || h < MIN_SIDE)
        begin
            clear_histogram();
            res = '0;
            res.status      = STATUS_BAD_SIZE;
            res.rank        = RANK_FIRST;
            res.last_result = 1'b1;
            color_q.push_back(res);
            return;
        end
        n = shadow_blocks;
        if (n < 1)
            n = 1;
        if (n > LEVELS)
            n = LEVELS;
        stp = (510 + n) / (2 * n);
        bin = (level_of(pb, stp) * LEVELS + level_of(pg, stp)) * LEVELS + level_of(pr, stp);
        if (bin_tally[bin] != CNT_MAX)
            bin_tally[bin] = bin_tally[bin] + 1'b1;
        total = w * h;
        if (frame_fill + 1 < total)
        begin
            frame_fill++;
            return;
        end
        best_b = 0;
        best_t = 0;
        sec_b  = 0;
        sec_t  = 0;
        // Strict comparisons keep the lower bin on a tie.
        for (int i = 0; i < NBINS; i++)
        begin
            c = bin_tally[i];
            if (c > best_t)
            begin
                sec_b  = best_b;
                sec_t  = best_t;
                best_b = i;
                best_t = c;
            end
            else if (c > sec_t)
            begin
                sec_b = i;
                sec_t = c;
            end
        end
        if (best_t > 0)
        begin
            color_q.push_back(make_color(RANK_FIRST, best_b, best_t, total, stp, sec_t == 0));
            if (sec_t > 0)
                color_q.push_back(make_color(RANK_SECOND, sec_b, sec_t, total, stp, 1'b1));
        end
        clear_histogram();
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        stim_t s;
        s = '0;
        s.kind    = STIM_CFG;
        s.reg_idx = idx;
        s.reg_val = CFG_DATA_W'(val);
        pending.push_back(s);
    endtask

    task automatic add_pixel(int unsigned pb, int unsigned pg, int unsigned pr);
        stim_t s;
        s = '0;
        s.kind    = STIM_PIXEL;
        s.gap_pct = 7'(phase_gap);
        s.b       = PIX_W'(pb);
        s.g       = PIX_W'(pg);
        s.r       = PIX_W'(pr);
        pending.push_back(s);
    endtask

    task automatic add_random_pixel();
        add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    endtask

    task automatic set_frame(int unsigned blocks, int unsigned w, int unsigned h);
        add_cfg(REG_BLOCKS, blocks);
        add_cfg(REG_WIDTH, w);
        add_cfg(REG_HEIGHT, h);
    endtask

    // Pixels drawn mostly from a few random colors, so that a handful of bins
    // dominate, with some scattered noise.
    task automatic add_palette_pixels(int unsigned count, int unsigned colors);
        logic [23:0] palette [4];
        int unsigned k;
        foreach (palette[i])
            palette[i] = 24'($urandom());
        repeat (count)
        begin
            k = $urandom_range(colors - 1);
            if ($urandom_range(1) == 1)
                k = k / 2;
            if ($urandom_range(9) == 0)
                add_random_pixel();
            else
                add_pixel(palette[k][23:16], palette[k][15:8], palette[k][7:0]);
        end
    endtask

    // Monitor, predictor and watchdog.
    always @(posedge clk)
    begin : monitor_proc
        color_result_t want;
        item_taken = 1'b0;
        cfg_taken  = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BLOCKS: shadow_blocks = cfg_data[BLK_W-1:0];
                    REG_WIDTH:  shadow_width = cfg_data;
                    REG_HEIGHT: shadow_height = cfg_data;
                    default:    ;
                endcase
                cfg_taken = 1'b1;
                cfg_writes++;
            end
            if (start && !busy)
            begin
                predict_pixel(blue, green, red);
                item_taken = 1'b1;
                pixels_sent++;
            end
            if (result_valid)
            begin
                if (color_q.size() == 0)
                    report_error($sformatf("result with none expected (status %0d rank %0d)",
                                           status, rank));
                else
                begin
                    want = color_q.pop_front();
                    if ($isunknown({status, rank, color_blue, color_green, color_red,
                                    pixel_count, share, last_result}))
                        report_error("result carries unknown bits");
                    check_field("status", status, want.status);
                    check_field("rank", rank, want.rank);
                    check_field("color_blue", color_blue, want.color_blue);
                    check_field("color_green", color_green, want.color_green);
                    check_field("color_red", color_red, want.color_red);
                    check_field("pixel_count", pixel_count, want.pixel_count);
                    check_field("share", share, want.share);
                    check_field("last_result", last_result, want.last_result);
                    if (want.status == STATUS_BAD_SIZE)
                        rejects_seen++;
                    else if (want.last_result)
                        frames_done++;
                end
            end
            if (item_taken || cfg_taken || result_valid)
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // Driver: one item at a time, changed on the falling edge.
    always @(negedge clk)
    begin : driver_proc
        logic  next_start;
        logic  next_cfg;
        stim_t head;
        if (rst_n)
        begin
            next_start = start;
            next_cfg   = cfg_valid;
            if (item_taken)
                next_start = 1'b0;
            if (cfg_taken)
                next_cfg = 1'b0;
            if (!next_start && !next_cfg && pending.size() != 0)
            begin
                head = pending[0];
                if (head.kind == STIM_CFG)
                begin
                    // Registers change only once the block has gone quiet.
                    if (color_q.size() != 0)
                        quiet_cycles = 0;
                    else if (quiet_cycles < SETTLE_CYCLES)
                        quiet_cycles++;
                    else
                    begin
                        void'(pending.pop_front());
                        cfg_index <= head.reg_idx;
                        cfg_data  <= head.reg_val;
                        next_cfg  = 1'b1;
                    end
                end
                else if ($urandom_range(99) >= head.gap_pct)
                begin
                    void'(pending.pop_front());
                    blue         <= head.b;
                    green        <= head.g;
                    red          <= head.r;
                    next_start   = 1'b1;
                    quiet_cycles = 0;
                end
            end
            start     <= next_start;
            cfg_valid <= next_cfg;
        end
    end

    initial
    begin
        int unsigned w;
        int unsigned h;

        // Pixels against the reset-time frame size; the rejection below drops them.
        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);
        add_pixel(8'hAA, 8'h55, 8'hAA);
        // Undersized frames: each pixel is rejected on its own.
        add_cfg(REG_WIDTH, 15);
        add_pixel(8'h55, 8'hAA, 8'h55);
        add_pixel(255, 0, 255);
        add_cfg(REG_WIDTH, 16);
        add_cfg(REG_HEIGHT, 15);
        add_pixel(0, 255, 0);
        add_cfg(REG_WIDTH, 1);
        add_cfg(REG_HEIGHT, 1);
        add_random_pixel();
        add_cfg(REG_WIDTH, 8191);
        add_cfg(REG_HEIGHT, 8);
        add_random_pixel();
        add_cfg(REG_WIDTH, 8);
        add_cfg(REG_HEIGHT, 8191);
        add_random_pixel();
        // A frame of one color gives a single result with a full share.
        set_frame(8, 16, 16);
        repeat (256)
            add_pixel(255, 0, 170);
        // Two colors tied: the lower bin must come out first.
        set_frame(16, 16, 16);
        repeat (128)
        begin
            add_pixel(200, 10, 10);
            add_pixel(10, 200, 10);
        end
        // A block count of zero behaves as one; green-only and blue-only tie.
        set_frame(0, 16, 16);
        repeat (100)
            add_pixel(255, 0, 0);
        repeat (56)
            add_pixel(0, 0, 0);
        repeat (100)
            add_pixel(0, 255, 0);
        // A block count above the level count is clamped.
        set_frame(31, 17, 16);
        add_palette_pixels(272, 3);
        // A rejected pixel throws away a partly counted frame.
        set_frame(5, 16, 16);
        add_palette_pixels(100, 2);
        add_cfg(REG_WIDTH, 15);
        add_random_pixel();
        add_cfg(REG_WIDTH, 16);
        add_palette_pixels(256, 2);
        // Size shrunk and block count changed in mid-frame; the next pixel ends the frame.
        set_frame(4, 32, 16);
        add_palette_pixels(300, 2);
        add_cfg(REG_BLOCKS, 3);
        add_cfg(REG_WIDTH, 16);
        add_palette_pixels(1, 1);
        // An oversized width is held at the largest side.
        set_frame(12, 8191, 16);
        add_palette_pixels(MAX_SIDE * 16, 4);

        for (int ph = 0; ph < 22; ph++)
        begin
            case (ph % 4)
                0:       phase_gap = GAP_NONE;
                1:       phase_gap = GAP_HEAVY;
                2:       phase_gap = GAP_LIGHT;
                default: phase_gap = GAP_NONE;
            endcase
            if ($urandom_range(4) == 0)
            begin
                if ($urandom_range(1) == 1)
                begin
                    add_cfg(REG_WIDTH, $urandom_range(MIN_SIDE - 1, 1));
                    add_cfg(REG_HEIGHT, $urandom_range(8191, 1));
                end
                else
                begin
                    add_cfg(REG_WIDTH, $urandom_range(8191, 1));
                    add_cfg(REG_HEIGHT, $urandom_range(MIN_SIDE - 1, 1));
                end
                repeat ($urandom_range(12, 4))
                    add_random_pixel();
            end
            else
            begin
                w = ($urandom_range(3) == 0) ? $urandom_range(24, MIN_SIDE) : MIN_SIDE;
                h = ($urandom_range(3) == 0) ? $urandom_range(20, MIN_SIDE) : MIN_SIDE;
                set_frame($urandom_range(31), w, h);
                repeat ($urandom_range(2, 1))
                    add_palette_pixels(w * h, $urandom_range(4, 1));
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || start || cfg_valid)
            @(negedge clk);
        while (color_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (color_q.size() != 0)
            report_error($sformatf("%0d expected results never arrived", color_q.size()));

        $display("Covered %0d pixels and %0d register writes: %0d frames reported,",
                 pixels_sent, cfg_writes, frames_done);
        $display("%0d undersized-frame rejections, %0d mismatches.",
                 rejects_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dch2_pkg.sv
sv/dch2_quant.sv
sv/dch2_hist.sv
sv/dch2_share.sv
sv/dominant_color_histogram_top2_top.sv
dv/dominant_color_histogram_top2_top_test.sv
